/* rtl/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the command frame decoder
// Frame record passed from the byte collector to the decoder, the decoded
// event, the configuration bundle and the command/kind/register codes.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int OUTPUT_COUNT = 8;
    localparam int FIFO_DEPTH   = 2;
    localparam int KEEP_BYTES   = 4;

    // command codes (first byte of a frame)
    localparam logic [7:0] CMD_TEMPO   = 8'h00;
    localparam logic [7:0] CMD_RATIO   = 8'h01;
    localparam logic [7:0] CMD_MODE    = 8'h02;
    localparam logic [7:0] CMD_TRIGGER = 8'h04;
    localparam logic [7:0] CMD_PROB    = 8'h05;

    localparam logic [7:0] MASK_SELECT = 8'hFF;
    localparam logic [7:0] PROB_MAX    = 8'd100;

    // event kinds
    localparam logic [2:0] KIND_TEMPO   = 3'd0;
    localparam logic [2:0] KIND_RATIO   = 3'd1;
    localparam logic [2:0] KIND_MODE    = 3'd2;
    localparam logic [2:0] KIND_TRIGGER = 3'd3;
    localparam logic [2:0] KIND_PROB    = 3'd4;

    // register word indexes
    localparam logic [1:0] REG_MIN_TEMPO    = 2'd0;
    localparam logic [1:0] REG_MAX_TEMPO    = 2'd1;
    localparam logic [1:0] REG_MAX_RUN_MODE = 2'd2;

    localparam logic [15:0] MIN_TEMPO_RST    = 16'd20;
    localparam logic [15:0] MAX_TEMPO_RST    = 16'd300;
    localparam logic [7:0]  MAX_RUN_MODE_RST = 8'd2;

    typedef struct packed {
        logic [2:0] len;   // bytes kept, 1..4
        logic [7:0] cmd;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } frame_t;

    typedef struct packed {
        logic        ok;
        logic [2:0]  kind;
        logic [2:0]  index;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
        logic [7:0]  mask;
        logic [15:0] count;
    } event_t;

    typedef struct packed {
        logic [15:0] min_tempo;
        logic [15:0] max_tempo;
        logic [7:0]  max_run_mode;
    } cfg_t;

endpackage

/* rtl/cfd_front.sv */
// ----------------------------------------------------------------------------
// cfd_front: byte collector
// Keeps the first four bytes of a frame and a saturating length count; on the
// last byte it pushes a complete frame record into the queue.
// ----------------------------------------------------------------------------
module cfd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      frame_byte,
    input  logic            last_byte,
    input  logic            q_ready,
    output logic            q_push,
    output cfd_pkg::frame_t q_frame
);

    logic [2:0] bytes_seen_reg;
    logic [2:0] bytes_seen_next;
    logic [7:0] frame_bytes_reg [cfd_pkg::KEEP_BYTES];
    logic [7:0] merged [cfd_pkg::KEEP_BYTES];
    logic       accept;
    logic       room;

    // a middle byte never needs queue space
    assign in_ready = !last_byte || q_ready;
    assign accept   = in_valid && in_ready;
    assign room     = (bytes_seen_reg < 3'(cfd_pkg::KEEP_BYTES));

    always_comb
    begin
        for (int i = 0; i < cfd_pkg::KEEP_BYTES; i++)
        begin
            merged[i] = (room && bytes_seen_reg[1:0] == 2'(i)) ? frame_byte
                                                                : frame_bytes_reg[i];
        end
    end

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        if (accept)
        begin
            if (last_byte)
                bytes_seen_next = 3'd0;
            else if (room)
                bytes_seen_next = bytes_seen_reg + 3'd1;
        end
    end

    assign q_push        = accept && last_byte;
    assign q_frame.len   = room ? (bytes_seen_reg + 3'd1) : 3'(cfd_pkg::KEEP_BYTES);
    assign q_frame.cmd   = merged[0];
    assign q_frame.b1    = merged[1];
    assign q_frame.b2    = merged[2];
    assign q_frame.b3    = merged[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bytes_seen_reg <= 3'd0;
        else
            bytes_seen_reg <= bytes_seen_next;
    end

    // byte store has no reset; only bytes counted in len are ever used
    always_ff @(posedge clk)
    begin
        if (accept && room)
            frame_bytes_reg[bytes_seen_reg[1:0]] <= frame_byte;
    end

endmodule

/* rtl/cfd_queue.sv */
// ----------------------------------------------------------------------------
// cfd_queue: two-entry frame queue
// Decouples the byte collector from the decoder so each side stalls alone.
// ----------------------------------------------------------------------------
module cfd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfd_pkg::frame_t push_frame,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output cfd_pkg::frame_t pop_frame
);

    localparam int PtrW = $clog2(cfd_pkg::FIFO_DEPTH);
    localparam int CntW = $clog2(cfd_pkg::FIFO_DEPTH + 1);

    cfd_pkg::frame_t entry_reg [cfd_pkg::FIFO_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntW'(cfd_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_frame  = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(cfd_pkg::FIFO_DEPTH - 1)) ? '0
                                                                              : wr_ptr_reg + PtrW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(cfd_pkg::FIFO_DEPTH - 1)) ? '0
                                                                              : rd_ptr_reg + PtrW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

endmodule

/* rtl/cfd_back.sv */
// ----------------------------------------------------------------------------
// cfd_back: frame decoder
// Decodes the queue head against the configuration and holds the event in an
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module cfd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cfd_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  cfd_pkg::frame_t q_frame,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output cfd_pkg::event_t out_event
);

    function automatic cfd_pkg::event_t decode(cfd_pkg::frame_t f, cfd_pkg::cfg_t c);
        cfd_pkg::event_t ev;
        logic [15:0]     tempo;
        logic            num_ok;
        logic [2:0]      idx;
        ev     = '0;
        num_ok = (f.b1 >= 8'd1) && (f.b1 <= 8'(cfd_pkg::OUTPUT_COUNT));
        idx    = 3'(f.b1 - 8'd1);
        tempo  = (f.len == 3'd2) ? {8'h00, f.b1} : {f.b1, f.b2};
        unique case (f.cmd)
            cfd_pkg::CMD_TEMPO:
            begin
                if (f.len >= 3'd2 && tempo >= c.min_tempo && tempo <= c.max_tempo)
                begin
                    ev.ok    = 1'b1;
                    ev.kind  = cfd_pkg::KIND_TEMPO;
                    ev.count = tempo;
                end
            end
            cfd_pkg::CMD_RATIO:
            begin
                if (f.len >= 3'd4 && num_ok && f.b2 != 8'd0 && f.b3 != 8'd0)
                begin
                    ev.ok      = 1'b1;
                    ev.kind    = cfd_pkg::KIND_RATIO;
                    ev.index   = idx;
                    ev.value_a = f.b2;
                    ev.value_b = f.b3;
                end
            end
            cfd_pkg::CMD_MODE:
            begin
                if (f.len >= 3'd3 && num_ok && f.b2 <= c.max_run_mode)
                begin
                    ev.ok      = 1'b1;
                    ev.kind    = cfd_pkg::KIND_MODE;
                    ev.index   = idx;
                    ev.value_b = f.b2;
                end
            end
            cfd_pkg::CMD_TRIGGER:
            begin
                if (f.len >= 3'd2)
                begin
                    if (f.b1 == cfd_pkg::MASK_SELECT)
                    begin
                        if (f.len >= 3'd3)
                        begin
                            ev.ok    = 1'b1;
                            ev.kind  = cfd_pkg::KIND_TRIGGER;
                            ev.mask  = f.b2;
                            ev.count = 16'd1;
                        end
                    end
                    else if (num_ok)
                    begin
                        ev.ok    = 1'b1;
                        ev.kind  = cfd_pkg::KIND_TRIGGER;
                        ev.mask  = 8'd1 << idx;
                        ev.count = 16'd1;
                    end
                end
            end
            cfd_pkg::CMD_PROB:
            begin
                if (f.len >= 3'd3 && num_ok && f.b2 <= cfd_pkg::PROB_MAX)
                begin
                    ev.ok      = 1'b1;
                    ev.kind    = cfd_pkg::KIND_PROB;
                    ev.index   = idx;
                    ev.value_a = f.b2;
                end
            end
            default:
            begin
                ev = '0;
            end
        endcase
        return ev;
    endfunction

    logic            out_valid_reg;
    cfd_pkg::event_t event_reg;

    // refill the output register whenever it is empty or being drained
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_event = event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            event_reg <= decode(q_frame, cfg);
    end

endmodule

/* rtl/command_frame_decoder.sv */
// ----------------------------------------------------------------------------
// command_frame_decoder: top level
// Byte collector, frame queue and decoder, plus the APB register block.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, also back-to-back frames, unless the frame queue is full.
// Path: the last byte's frame record is registered in the frame queue, then
//   decoded into the decoder's output register, which holds the event until taken.
// The two-entry queue lets bytes keep flowing while an event waits.
// Reset (rst_n low, async): byte count, queue and output valid clear; config
//   registers return to min_tempo 20, max_tempo 300, max_run_mode 2.
module command_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    // event channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        decode_ok,
    output logic [2:0]  event_kind,
    output logic [2:0]  output_index,
    output logic [7:0]  value_a,
    output logic [7:0]  value_b,
    output logic [7:0]  trigger_mask,
    output logic [15:0] event_count,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- register block ----------------
    // Word-addressed: paddr[3:2] picks the register, low bits ignored.
    logic [15:0]     min_tempo_reg;
    logic [15:0]     max_tempo_reg;
    logic [7:0]      max_run_mode_reg;
    logic            reg_write;
    logic [1:0]      reg_index;
    cfd_pkg::cfg_t   cfg;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tempo_reg    <= cfd_pkg::MIN_TEMPO_RST;
            max_tempo_reg    <= cfd_pkg::MAX_TEMPO_RST;
            max_run_mode_reg <= cfd_pkg::MAX_RUN_MODE_RST;
        end
        else if (reg_write)
        begin
            unique case (reg_index)
                cfd_pkg::REG_MIN_TEMPO:    min_tempo_reg    <= pwdata[15:0];
                cfd_pkg::REG_MAX_TEMPO:    max_tempo_reg    <= pwdata[15:0];
                cfd_pkg::REG_MAX_RUN_MODE: max_run_mode_reg <= pwdata[7:0];
                default:                   ; // unmapped word: write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            cfd_pkg::REG_MIN_TEMPO:    prdata = {16'd0, min_tempo_reg};
            cfd_pkg::REG_MAX_TEMPO:    prdata = {16'd0, max_tempo_reg};
            cfd_pkg::REG_MAX_RUN_MODE: prdata = {24'd0, max_run_mode_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Config must only change while idle (the block does not enforce this); the decoder reads it live.
    assign cfg.min_tempo    = min_tempo_reg;
    assign cfg.max_tempo    = max_tempo_reg;
    assign cfg.max_run_mode = max_run_mode_reg;

    // ---------------- datapath ----------------
    logic            q_push;
    logic            q_push_ready;
    cfd_pkg::frame_t q_in_frame;
    logic            q_pop;
    logic            q_valid;
    cfd_pkg::frame_t q_out_frame;
    cfd_pkg::event_t ev;

    // Front end: counts bytes, keeps the first four, pushes on the last beat.
    cfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .q_ready    (q_push_ready),
        .q_push     (q_push),
        .q_frame    (q_in_frame)
    );

    // Whole-frame records, two deep.
    cfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_frame (q_in_frame),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_frame  (q_out_frame)
    );

    // Back end: decode and hold one event beat.
    cfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_frame   (q_out_frame),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_event (ev)
    );

    assign decode_ok    = ev.ok;
    assign event_kind   = ev.kind;
    assign output_index = ev.index;
    assign value_a      = ev.value_a;
    assign value_b      = ev.value_b;
    assign trigger_mask = ev.mask;
    assign event_count  = ev.count;

endmodule

/* rtl/cfd_checker.sv */
// ----------------------------------------------------------------------------
// cfd_checker: port-level checks for the command frame decoder
// Watches the event channel and flags malformed event beats.
// ----------------------------------------------------------------------------
module cfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        decode_ok,
    input logic [2:0]  event_kind,
    input logic [2:0]  output_index,
    input logic [7:0]  value_a,
    input logic [7:0]  value_b,
    input logic [7:0]  trigger_mask,
    input logic [15:0] event_count
);

    // stalled beat keeps valid, ok, kind, mask and count
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decode_ok)
            && $stable(event_kind) && $stable(trigger_mask) && $stable(event_count))
        else $error("event beat changed while stalled");

    // rejected frame carries all-zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !decode_ok |-> event_kind == 3'd0 && output_index == 3'd0
            && value_a == 8'd0 && value_b == 8'd0 && trigger_mask == 8'd0
            && event_count == 16'd0)
        else $error("rejected event with nonzero fields");

    // trigger event: count of one, no index or values
    a_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && decode_ok && event_kind == cfd_pkg::KIND_TRIGGER
            |-> event_count == 16'd1 && output_index == 3'd0
            && value_a == 8'd0 && value_b == 8'd0)
        else $error("malformed trigger event");

    // only trigger events carry a mask
    a_mask_only_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != cfd_pkg::KIND_TRIGGER |-> trigger_mask == 8'd0)
        else $error("mask on non-trigger event");

endmodule

bind command_frame_decoder cfd_checker u_cfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .decode_ok    (decode_ok),
    .event_kind   (event_kind),
    .output_index (output_index),
    .value_a      (value_a),
    .value_b      (value_b),
    .trigger_mask (trigger_mask),
    .event_count  (event_count)
);
